// ----- design/iir_direct_form1_filter_defines.svh -----
// Assertion macros shared by the IIR filter RTL.
// Depends on nothing; files that check properties include this header.
`ifndef IIR_DIRECT_FORM1_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM1_FILTER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define IIRDF1_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define IIRDF1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/iirdf1_pkg.sv -----
// Shared types and constants for the direct-form-I IIR filter.
// Depends on nothing; used by the tap cell and the top level.
package iirdf1_pkg;

    localparam int COEF_W    = 24;
    localparam int NUM_REGS  = 7;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } t_reg_idx;

    localparam t_coef COEF_B0_RESET = t_coef'(24'sd1048576);

endpackage

// ----- design/iirdf1_cell.sv -----
// One tap of the filter: holds one input and one output history sample,
// adds its feedforward product to the running sum and subtracts its feedback product. Depends on iirdf1_pkg.
module iirdf1_cell
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 43
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  t_coef                         i_coef_b,
    input  t_coef                         i_coef_a,
    input  logic signed [ACC_W-1:0]       i_psum,
    output logic signed [SAMPLE_BITS-1:0] o_x,
    output logic signed [SAMPLE_BITS-1:0] o_y,
    output logic signed [ACC_W-1:0]       o_psum
);

    localparam int PROD_W = COEF_W + SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [PROD_W-1:0]      w_prod_b;
    logic signed [PROD_W-1:0]      w_prod_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_advance) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign w_prod_b = i_coef_b * r_x;
    assign w_prod_a = i_coef_a * r_y;
    assign o_psum   = i_psum + ACC_W'(w_prod_b) - ACC_W'(w_prod_a);
    assign o_x      = r_x;
    assign o_y      = r_y;

endmodule

// ----- design/iir_direct_form1_filter.sv -----
// Channel   Dir  Beat contents (low bits first)
// s_axis    in   tdata: sample
// m_axis    out  tdata: filtered; tuser: clipped
// cfg       in   index: register number; data: coefficient value
//
// One sample enters per cycle unless the output is stalled; its result is
// registered and offered on the following cycle, at one beat per cycle.
// The whole multiply-accumulate, shift and saturation are combinational because
// each output feeds the next sample through the first tap cell.
// Reset clears the histories and loads the default coefficients (b0 = 1.0).
// A stalled output blocks the input only while the output register is full.
// Depends on iirdf1_pkg, iirdf1_cell and iir_direct_form1_filter_defines.svh.
`include "iir_direct_form1_filter_defines.svh"

module iir_direct_form1_filter
    import iirdf1_pkg::*;
#(
    parameter int ORDER          = 3,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // filtered
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // clipped
    output logic                                 m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_index,
    input  logic [COEF_W-1:0]                    i_cfg_data
);

    localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PROD_W  = COEF_W + SAMPLE_BITS;
    localparam int GROW_W  = $clog2(2 * ORDER + 1);
    localparam int ACC_MIN = PROD_W + GROW_W;
    localparam int ACC_W   = (ACC_MIN > COEF_FRAC_BITS + SAMPLE_BITS) ?
                             ACC_MIN : COEF_FRAC_BITS + SAMPLE_BITS + 1;
    localparam int SH_W    = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_coef                         r_coef [0:NUM_REGS-1];
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered;
    logic                          r_clipped;

    logic                          w_accept;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic signed [PROD_W-1:0]      w_prod_b0;
    logic signed [ACC_W-1:0]       w_psum [0:ORDER];
    logic signed [SAMPLE_BITS-1:0] w_x    [0:ORDER];
    logic signed [SAMPLE_BITS-1:0] w_y    [0:ORDER];
    logic signed [SH_W-1:0]        w_shift;
    logic [SH_W-SAMPLE_BITS:0]     w_hi;
    logic                          w_clip;
    logic signed [SAMPLE_BITS-1:0] w_y_new;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= (i == int'(REG_B0)) ? COEF_B0_RESET : t_coef'(0);
            end
        end else if (i_cfg_valid && o_cfg_ready &&
                     (32'(i_cfg_index) < 32'(NUM_REGS))) begin
            r_coef[i_cfg_index] <= t_coef'(i_cfg_data);
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_sample      = s_axis_tdata[SAMPLE_BITS-1:0];

    assign w_prod_b0 = r_coef[REG_B0] * w_sample;
    assign w_psum[0] = ACC_W'(w_prod_b0);
    assign w_x[0]    = w_sample;
    assign w_y[0]    = w_y_new;

    for (genvar k = 1; k <= ORDER; k++) begin : g_tap
        iirdf1_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .ACC_W      (ACC_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_advance(w_accept),
            .i_x      (w_x[k-1]),
            .i_y      (w_y[k-1]),
            .i_coef_b (r_coef[k]),
            .i_coef_a (r_coef[int'(REG_A1) + k - 1]),
            .i_psum   (w_psum[k-1]),
            .o_x      (w_x[k]),
            .o_y      (w_y[k]),
            .o_psum   (w_psum[k])
        );
    end

    assign w_shift = w_psum[ORDER][ACC_W-1:COEF_FRAC_BITS];
    assign w_hi    = w_shift[SH_W-1:SAMPLE_BITS-1];
    assign w_clip  = !((&w_hi) || !(|w_hi));

    always_comb begin
        if (!w_clip) begin
            w_y_new = w_shift[SAMPLE_BITS-1:0];
        end else if (w_shift[SH_W-1]) begin
            w_y_new = SMIN;
        end else begin
            w_y_new = SMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_filtered <= w_y_new;
            r_clipped  <= w_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'($unsigned(r_filtered));
    assign m_axis_tuser  = r_clipped;

    `IIRDF1_ASSERT_NOW(a_clip_is_rail, i_clk, i_rst_n,
        r_out_valid && r_clipped, (r_filtered == SMAX) || (r_filtered == SMIN),
        "clipped result is not at a saturation rail")
    `IIRDF1_ASSERT_NOW(a_no_accept_when_full, i_clk, i_rst_n,
        r_out_valid && !m_axis_tready, !s_axis_tready,
        "input taken while the held result was not drained")
    `IIRDF1_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n,
        w_accept, r_out_valid && $stable(r_coef[REG_B0]) || r_out_valid,
        "accepted sample produced no result beat")

endmodule
